[hw/rtl/srif_pkg.sv]
// Shared operation codes, status codes and cell control type for the strided index filter.
package srif_pkg;

  localparam logic [1:0] OP_CLEAR = 2'd0;
  localparam logic [1:0] OP_ADD   = 2'd1;
  localparam logic [1:0] OP_QUERY = 2'd2;

  localparam logic [1:0] ST_OK        = 2'd0;
  localparam logic [1:0] ST_FULL      = 2'd1;
  localparam logic [1:0] ST_ZERO_STEP = 2'd2;

  typedef struct packed {
    logic shift;
    logic load;
    logic div;
    logic chain;
  } srif_ctrl_t;

endpackage

[hw/rtl/strided_range_index_filter_unit.sv]
// Top level of the strided index filter: command sequencer and the chain of rule cells.
//
// Usage: a command beat is taken at a rising edge where start is high and busy is low.
// operation_i selects clear, add rule or query; the other fields carry the rule or index.
// Every command gives exactly one result beat: done_o is high for one cycle with
// selected_o and status_o, and the receiver must take it in that cycle.
// Clear, add and unused codes answer in the cycle after the command; busy stays low,
// so a new command may follow right away.
// A query with an empty table also answers in the next cycle with selected set.
// Otherwise a query is accepted into the divide state, then runs the chain and result
// states, with busy high until the result beat.
// Each cell reduces its offset by its stride one bit per cycle, all cells together,
// and the per-cell hits are then gathered along the chain one cell per cycle.
// An added rule enters the first cell and pushes the stored rules one cell along.
// Reset empties the rule table and drops any query in progress.
module strided_range_index_filter_unit
  import srif_pkg::*;
#(
  parameter int MAX_RULES  = 8,
  parameter int INDEX_BITS = 32
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  start,
  output logic                  busy,
  input  logic [1:0]            operation_i,
  input  logic [INDEX_BITS-1:0] range_start_i,
  input  logic [INDEX_BITS-1:0] range_stop_i,
  input  logic                  open_ended_i,
  input  logic [INDEX_BITS-1:0] stride_i,
  input  logic [INDEX_BITS-1:0] index_i,
  output logic                  done_o,
  output logic                  selected_o,
  output logic [1:0]            status_o
);

  localparam int CW     = $clog2(MAX_RULES + 1);
  localparam int CntMax = (INDEX_BITS > MAX_RULES) ? INDEX_BITS : MAX_RULES;
  localparam int CNTW   = $clog2(CntMax);

  typedef enum logic [1:0] {
    S_IDLE,
    S_DIV,
    S_CHAIN,
    S_RESULT
  } state_e;

  state_e          state_q;
  logic [CNTW-1:0] cnt_q;
  logic [CW-1:0]   count_q;
  logic            done_q, sel_q;
  logic [1:0]      status_q;
  logic            accept;
  logic            table_full;
  srif_ctrl_t      ctrl;

  logic [INDEX_BITS-1:0] first_w [MAX_RULES+1];
  logic [INDEX_BITS-1:0] last_w  [MAX_RULES+1];
  logic [INDEX_BITS-1:0] step_w  [MAX_RULES+1];
  logic                  unb_w   [MAX_RULES+1];
  logic                  acc_w   [MAX_RULES+1];

  assign accept     = start && (state_q == S_IDLE);
  assign table_full = (count_q == CW'(MAX_RULES));

  always_comb begin
    ctrl.shift = accept && (operation_i == OP_ADD) && !table_full && (stride_i != '0);
    ctrl.load  = accept && (operation_i == OP_QUERY) && (count_q != '0);
    ctrl.div   = (state_q == S_DIV);
    ctrl.chain = (state_q == S_CHAIN);
  end

  assign first_w[0] = range_start_i;
  assign last_w[0]  = range_stop_i;
  assign step_w[0]  = stride_i;
  assign unb_w[0]   = open_ended_i;
  assign acc_w[0]   = 1'b0;

  for (genvar i = 0; i < MAX_RULES; i++) begin : g_cell
    srif_cell #(
      .INDEX_BITS(INDEX_BITS)
    ) u_cell (
      .clk_i  (clk_i),
      .rst_ni (rst_ni),
      .ctrl_i (ctrl),
      .first_i(first_w[i]),
      .last_i (last_w[i]),
      .step_i (step_w[i]),
      .unb_i  (unb_w[i]),
      .index_i(index_i),
      .valid_i(count_q > CW'(i)),
      .acc_i  (acc_w[i]),
      .first_o(first_w[i+1]),
      .last_o (last_w[i+1]),
      .step_o (step_w[i+1]),
      .unb_o  (unb_w[i+1]),
      .acc_o  (acc_w[i+1])
    );
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= S_IDLE;
      cnt_q    <= '0;
      count_q  <= '0;
      done_q   <= 1'b0;
      sel_q    <= 1'b0;
      status_q <= ST_OK;
    end else begin
      done_q   <= 1'b0;
      sel_q    <= 1'b0;
      status_q <= ST_OK;
      case (state_q)
        S_IDLE: begin
          if (accept) begin
            case (operation_i)
              OP_CLEAR: begin
                count_q <= '0;
                done_q  <= 1'b1;
              end
              OP_ADD: begin
                done_q <= 1'b1;
                if (table_full) begin
                  status_q <= ST_FULL;
                end else if (stride_i == '0) begin
                  status_q <= ST_ZERO_STEP;
                end else begin
                  count_q <= count_q + CW'(1);
                end
              end
              OP_QUERY: begin
                if (count_q == '0) begin
                  done_q <= 1'b1;
                  sel_q  <= 1'b1;
                end else begin
                  state_q <= S_DIV;
                  cnt_q   <= '0;
                end
              end
              default: begin
                done_q <= 1'b1;
              end
            endcase
          end
        end
        S_DIV: begin
          if (cnt_q == CNTW'(INDEX_BITS - 1)) begin
            state_q <= S_CHAIN;
            cnt_q   <= '0;
          end else begin
            cnt_q <= cnt_q + CNTW'(1);
          end
        end
        S_CHAIN: begin
          if (cnt_q == CNTW'(MAX_RULES - 1)) begin
            state_q <= S_RESULT;
            cnt_q   <= '0;
          end else begin
            cnt_q <= cnt_q + CNTW'(1);
          end
        end
        S_RESULT: begin
          done_q  <= 1'b1;
          sel_q   <= acc_w[MAX_RULES];
          state_q <= S_IDLE;
        end
        default: begin
          state_q <= S_IDLE;
        end
      endcase
    end
  end

  assign busy       = (state_q != S_IDLE);
  assign done_o     = done_q;
  assign selected_o = sel_q;
  assign status_o   = status_q;

endmodule

[hw/rtl/srif_cell.sv]
// One rule cell: holds a rule, checks its range and reduces the offset by its stride bit by bit.
module srif_cell
  import srif_pkg::*;
#(
  parameter int INDEX_BITS = 32
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  srif_ctrl_t            ctrl_i,
  input  logic [INDEX_BITS-1:0] first_i,
  input  logic [INDEX_BITS-1:0] last_i,
  input  logic [INDEX_BITS-1:0] step_i,
  input  logic                  unb_i,
  input  logic [INDEX_BITS-1:0] index_i,
  input  logic                  valid_i,
  input  logic                  acc_i,
  output logic [INDEX_BITS-1:0] first_o,
  output logic [INDEX_BITS-1:0] last_o,
  output logic [INDEX_BITS-1:0] step_o,
  output logic                  unb_o,
  output logic                  acc_o
);

  logic [INDEX_BITS-1:0] first_q, last_q, step_q;
  logic                  unb_q;
  logic [INDEX_BITS-1:0] dvd_q, dvd_d;
  logic [INDEX_BITS-1:0] rem_q, rem_d;
  logic                  inrange_q, inrange_d;
  logic                  acc_q, acc_d;
  logic [INDEX_BITS:0]   trial;
  logic [INDEX_BITS:0]   diff;

  assign trial = {rem_q, dvd_q[INDEX_BITS-1]};
  assign diff  = trial - {1'b0, step_q};

  always_comb begin
    dvd_d     = dvd_q;
    rem_d     = rem_q;
    inrange_d = inrange_q;
    acc_d     = acc_q;
    if (ctrl_i.load) begin
      dvd_d     = index_i - first_q;
      rem_d     = '0;
      inrange_d = (index_i >= first_q) && (unb_q || (index_i <= last_q));
      acc_d     = 1'b0;
    end else if (ctrl_i.div) begin
      dvd_d = {dvd_q[INDEX_BITS-2:0], 1'b0};
      if (!diff[INDEX_BITS]) begin
        rem_d = diff[INDEX_BITS-1:0];
      end else begin
        rem_d = trial[INDEX_BITS-1:0];
      end
    end else if (ctrl_i.chain) begin
      acc_d = acc_i | (valid_i & inrange_q & (rem_q == '0));
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctrl_i.shift) begin
      first_q <= first_i;
      last_q  <= last_i;
      step_q  <= step_i;
      unb_q   <= unb_i;
    end
    dvd_q     <= dvd_d;
    rem_q     <= rem_d;
    inrange_q <= inrange_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      acc_q <= 1'b0;
    end else begin
      acc_q <= acc_d;
    end
  end

  assign first_o = first_q;
  assign last_o  = last_q;
  assign step_o  = step_q;
  assign unb_o   = unb_q;
  assign acc_o   = acc_q;

endmodule
